FILE: rtl/mvw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvw_pkg
// Shared types and fixed constants of the multi-voice wavetable oscillator.
// ----------------------------------------------------------------------------
package mvw_pkg;

    // field widths fixed by the beat format
    localparam int CMD_W   = 3;
    localparam int VOICE_W = 2;
    localparam int VALUE_W = 16;
    localparam int TAB_AW  = 10;
    localparam int TAB_DW  = 16;
    localparam int CMP_W   = 16;
    localparam int LOUD_W  = 7;
    localparam int SHIFT_W = 3;

    // volume to attenuation mapping
    localparam logic [LOUD_W-1:0] LOUD_MAX   = 7'd127;
    localparam int                LOUD_SHIFT = 4;

    // results of one tick are capped at this count
    localparam int RESULT_LIMIT = 3;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_ENABLE  = 3'd0,
        CMD_DISABLE = 3'd1,
        CMD_WAVE    = 3'd2,
        CMD_NOTE    = 3'd3,
        CMD_VOLUME  = 3'd4,
        CMD_FREQ    = 3'd5,
        CMD_TICK    = 3'd6,
        CMD_TABLE   = 3'd7
    } t_cmd;

    // operations that reach the memory stage
    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_NOTE_ON = 2'd1,
        OP_STEP    = 2'd2,
        OP_TABLE   = 2'd3
    } t_op;

endpackage

FILE: rtl/mvw_step_mod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvw_step_mod
// Three-stage pipeline that reduces a frequency step modulo PHASE_MAX by
// reciprocal multiplication, product back-multiplication and one correction.
// ----------------------------------------------------------------------------
module mvw_step_mod
    import mvw_pkg::*;
#(
    parameter int PHASE_MAX = 1023
) (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [VALUE_W-1:0]             i_value,
    output logic [$clog2(PHASE_MAX)-1:0]   o_residue
);

    localparam int PH_W = $clog2(PHASE_MAX + 1);
    localparam int SR_W = $clog2(PHASE_MAX);
    // ceiling of 2^32 / PHASE_MAX gives an exact quotient for 16-bit values
    localparam longint unsigned RECIP = ((64'd1 << 32) + PHASE_MAX - 1) / PHASE_MAX;
    localparam int R_W  = $clog2(RECIP + 1);
    localparam int P1_W = VALUE_W + R_W;
    localparam int Q_W  = P1_W - 32;
    localparam int P2_W = Q_W + PH_W;
    localparam int D_W  = VALUE_W + 1;

    logic [P1_W-1:0]    r_prod1;
    logic [VALUE_W-1:0] r_val1;
    logic [P2_W-1:0]    r_prod2;
    logic [VALUE_W-1:0] r_val2;
    logic [SR_W-1:0]    r_res;

    logic [P1_W-1:0]    n_prod1;
    logic [Q_W-1:0]     quot;
    logic [P2_W-1:0]    n_prod2;
    logic [D_W-1:0]     diff;
    logic [SR_W-1:0]    n_res;

    // quotient estimate
    assign n_prod1 = P1_W'(i_value) * P1_W'(RECIP);
    assign quot    = r_prod1[P1_W-1:32];

    // quotient times modulus
    assign n_prod2 = P2_W'(quot) * P2_W'(PHASE_MAX);

    // remainder with one correction step
    always_comb begin
        diff = D_W'(r_val2) - D_W'(r_prod2);
        if (diff >= D_W'(PHASE_MAX)) begin
            diff = diff - D_W'(PHASE_MAX);
        end
        n_res = SR_W'(diff);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod1 <= n_prod1;
            r_val1  <= i_value;
            r_prod2 <= n_prod2;
            r_val2  <= r_val1;
            r_res   <= n_res;
        end
    end

    assign o_residue = r_res;

endmodule

FILE: rtl/multi_voice_wavetable_oscillator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_voice_wavetable_oscillator_core
// Multi-voice phase-accumulator oscillator with a shared wave table that
// produces PWM compare values, one per enabled voice on each sample tick.
// ----------------------------------------------------------------------------
//  channel   | handshake          | payload
//  ----------+--------------------+------------------------------------------
//  command   | i_valid / o_stall  | i_command i_voice i_value i_table_address
//            |                    | i_table_word
//  result    | o_valid / i_stall  | o_out_voice o_compare_value o_last
//
//  A new beat enters the issue stage once the last one is done; a tick stays
//  there until it has given one result per enabled voice (one to three), or
//  gives none if no voice is enabled. The issue stage, which reads the voice
//  memory for one voice per cycle while no result stalls, sets the result rate.
//  Reset clears the enable, play and wave settings and the voice memory valid
//  bits at once and sets every volume to LOUD_MAX; the wave table is not
//  cleared. A stalled result freezes the whole pipeline and raises o_stall.
// ----------------------------------------------------------------------------
module multi_voice_wavetable_oscillator_core
    import mvw_pkg::*;
#(
    parameter int PHASE_MAX   = 1023,
    parameter int FULL_SCALE  = 1023,
    parameter int VOICE_COUNT = 3
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // command channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [CMD_W-1:0]   i_command,
    input  logic [VOICE_W-1:0] i_voice,
    input  logic [VALUE_W-1:0] i_value,
    input  logic [TAB_AW-1:0]  i_table_address,
    input  logic [TAB_DW-1:0]  i_table_word,
    // result channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic [VOICE_W-1:0] o_out_voice,
    output logic [CMP_W-1:0]   o_compare_value,
    output logic               o_last
);

    localparam int PH_W = $clog2(PHASE_MAX + 1);
    localparam int SR_W = $clog2(PHASE_MAX);
    localparam int VI_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int T_W  = PH_W + 1;
    localparam int TAB_DEPTH = 1 << TAB_AW;

    localparam logic [PH_W-1:0]  PH_MAX   = PH_W'(PHASE_MAX);
    localparam logic [PH_W-1:0]  PH_HALF  = PH_W'(PHASE_MAX / 2);
    localparam logic [CMP_W-1:0] CMP_FULL = CMP_W'(FULL_SCALE);
    localparam logic [CMP_W-1:0] CMP_HALF = CMP_W'(FULL_SCALE / 2);

    // one voice memory entry
    typedef struct packed {
        logic [PH_W-1:0] phase;
        logic [SR_W-1:0] step_res;
        logic            step_nz;
    } t_ventry;

    // ------------------------------------------------------------------
    // declarations
    // ------------------------------------------------------------------
    logic adv;
    logic move;
    logic accept;

    // stage a and b: beat registers while the step residue is formed
    logic               r_a_valid, r_b_valid, r_c_valid;
    t_cmd               r_a_cmd, r_b_cmd, r_c_cmd;
    logic [VOICE_W-1:0] r_a_voice, r_b_voice, r_c_voice;
    logic [VALUE_W-1:0] r_a_value, r_b_value, r_c_value;
    logic [TAB_AW-1:0]  r_a_addr, r_b_addr, r_c_addr;
    logic [TAB_DW-1:0]  r_a_word, r_b_word, r_c_word;
    logic [SR_W-1:0]    c_res;

    // voice settings
    logic [VOICE_COUNT-1:0] r_en;
    logic [VOICE_COUNT-1:0] r_play;
    logic [VOICE_COUNT-1:0] r_square;
    logic [LOUD_W-1:0]      r_loud [VOICE_COUNT];

    // issue stage
    logic [VOICE_COUNT-1:0] r_c_done;
    logic [1:0]             r_c_cnt;
    logic [VOICE_COUNT-1:0] c_pend;
    logic [VOICE_COUNT-1:0] c_rest;
    logic [VI_W-1:0]        c_sel;
    logic                   c_has;
    logic                   c_tick;
    logic                   c_last;
    logic                   c_free;
    logic                   c_vok;
    logic [VI_W-1:0]        c_vidx;
    logic [VI_W-1:0]        c_raddr;
    logic                   c_op_valid;
    t_op                    c_op;
    logic [SHIFT_W-1:0]     c_shift;

    // memory stage
    logic               r_d_valid;
    t_op                r_d_op;
    logic [VI_W-1:0]    r_d_voice;
    logic               r_d_last;
    logic               r_d_play;
    logic               r_d_square;
    logic [SHIFT_W-1:0] r_d_shift;
    logic [SR_W-1:0]    r_d_res;
    logic               r_d_nz;
    logic [TAB_AW-1:0]  r_d_addr;
    logic [TAB_DW-1:0]  r_d_word;
    logic               r_d_rok;

    // voice memory with valid bits and a write forward register
    t_ventry                r_vmem [VOICE_COUNT];
    t_ventry                r_vm_rd;
    logic [VOICE_COUNT-1:0] r_vm_valid;
    logic                   r_fw_valid;
    logic [VI_W-1:0]        r_fw_voice;
    t_ventry                r_fw_data;

    t_ventry            d_ent;
    logic [T_W-1:0]     d_sum;
    logic [PH_W-1:0]    d_newp;
    logic               d_wen;
    t_ventry            d_wdata;
    logic [TAB_AW-1:0]  d_tidx;

    // wave table
    logic [TAB_DW-1:0]  r_tab [TAB_DEPTH];
    logic [TAB_DW-1:0]  r_tab_rd;

    // output stage
    logic               r_e_valid;
    logic [VOICE_W-1:0] r_e_voice;
    logic               r_e_last;
    logic               r_e_play;
    logic               r_e_square;
    logic               r_e_sqhi;
    logic [SHIFT_W-1:0] r_e_shift;

    // ------------------------------------------------------------------
    // flow control
    // ------------------------------------------------------------------
    assign adv     = !r_e_valid || !i_stall;
    assign move    = adv && c_free;
    assign o_stall = !move;
    assign accept  = i_valid && move;

    // ------------------------------------------------------------------
    // front pipeline: a, b, c
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (move) begin
            r_a_valid <= accept;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_a_cmd   <= t_cmd'(i_command);
            r_a_voice <= i_voice;
            r_a_value <= i_value;
            r_a_addr  <= i_table_address;
            r_a_word  <= i_table_word;
            r_b_cmd   <= r_a_cmd;
            r_b_voice <= r_a_voice;
            r_b_value <= r_a_value;
            r_b_addr  <= r_a_addr;
            r_b_word  <= r_a_word;
            r_c_cmd   <= r_b_cmd;
            r_c_voice <= r_b_voice;
            r_c_value <= r_b_value;
            r_c_addr  <= r_b_addr;
            r_c_word  <= r_b_word;
        end
    end

    // step residue, aligned with stage c
    mvw_step_mod #(
        .PHASE_MAX (PHASE_MAX)
    ) u_step_mod (
        .i_clk     (i_clk),
        .i_en      (move),
        .i_value   (i_value),
        .o_residue (c_res)
    );

    // ------------------------------------------------------------------
    // issue stage: tick expansion and command decode
    // ------------------------------------------------------------------
    always_comb begin
        c_pend = r_en & ~r_c_done;
        c_sel  = '0;
        c_has  = 1'b0;
        // lowest pending voice
        for (int i = VOICE_COUNT - 1; i >= 0; i--) begin
            if (c_pend[i]) begin
                c_sel = VI_W'(i);
                c_has = 1'b1;
            end
        end
        c_rest = c_pend & ~(VOICE_COUNT'(1) << c_sel);
        c_tick = r_c_valid && (r_c_cmd == CMD_TICK);
        c_last = (c_rest == '0) || (r_c_cnt == 2'(RESULT_LIMIT - 1));
        c_free = !c_tick || !c_has || c_last;
    end

    assign c_vok   = 32'(r_c_voice) < VOICE_COUNT;
    assign c_vidx  = VI_W'(r_c_voice);
    assign c_raddr = c_tick ? c_sel : c_vidx;
    assign c_shift = SHIFT_W'((LOUD_MAX - r_loud[c_sel]) >> LOUD_SHIFT);

    // operation handed to the memory stage
    always_comb begin
        c_op_valid = 1'b0;
        c_op       = OP_TICK;
        if (r_c_valid) begin
            unique case (r_c_cmd)
                CMD_TICK: begin
                    c_op_valid = c_has;
                    c_op       = OP_TICK;
                end
                CMD_NOTE: begin
                    c_op_valid = c_vok && (r_c_value != '0);
                    c_op       = OP_NOTE_ON;
                end
                CMD_FREQ: begin
                    c_op_valid = c_vok;
                    c_op       = OP_STEP;
                end
                CMD_TABLE: begin
                    c_op_valid = 1'b1;
                    c_op       = OP_TABLE;
                end
                CMD_ENABLE, CMD_DISABLE, CMD_WAVE, CMD_VOLUME: begin
                    c_op_valid = 1'b0;
                    c_op       = OP_TICK;
                end
                default: begin
                    c_op_valid = 1'b0;
                    c_op       = OP_TICK;
                end
            endcase
        end
    end

    // tick progress within the issue stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_done <= '0;
            r_c_cnt  <= '0;
        end else if (move) begin
            r_c_done <= '0;
            r_c_cnt  <= '0;
        end else if (adv && c_tick) begin
            r_c_done <= r_c_done | (VOICE_COUNT'(1) << c_sel);
            r_c_cnt  <= r_c_cnt + 2'd1;
        end
    end

    // voice settings, updated in beat order at the issue stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en     <= '0;
            r_play   <= '0;
            r_square <= '0;
            for (int i = 0; i < VOICE_COUNT; i++) begin
                r_loud[i] <= LOUD_MAX;
            end
        end else if (move && r_c_valid && c_vok) begin
            unique case (r_c_cmd)
                CMD_ENABLE:  r_en[c_vidx] <= 1'b1;
                CMD_DISABLE: r_en[c_vidx] <= 1'b0;
                CMD_WAVE: begin
                    if (r_c_value <= VALUE_W'(1)) begin
                        r_square[c_vidx] <= r_c_value[0];
                    end
                end
                CMD_NOTE:    r_play[c_vidx] <= (r_c_value != '0);
                CMD_VOLUME:  r_loud[c_vidx] <= r_c_value[LOUD_W-1:0];
                CMD_FREQ, CMD_TICK, CMD_TABLE: begin
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // memory stage
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (adv) begin
            r_d_valid <= c_op_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d_op     <= c_op;
            r_d_voice  <= c_raddr;
            r_d_last   <= c_last;
            r_d_play   <= r_play[c_sel];
            r_d_square <= r_square[c_sel];
            r_d_shift  <= c_shift;
            r_d_res    <= c_res;
            r_d_nz     <= (r_c_value != '0);
            r_d_addr   <= r_c_addr;
            r_d_word   <= r_c_word;
            r_d_rok    <= r_vm_valid[c_raddr];
            r_vm_rd    <= r_vmem[c_raddr];
        end
    end

    // current entry: forwarded write, stored entry or reset value
    always_comb begin
        if (r_fw_valid && (r_fw_voice == r_d_voice)) begin
            d_ent = r_fw_data;
        end else if (r_d_rok) begin
            d_ent = r_vm_rd;
        end else begin
            d_ent = '0;
        end
    end

    // phase advance; the step is stored reduced modulo PHASE_MAX
    always_comb begin
        d_sum = T_W'(d_ent.phase) + T_W'(d_ent.step_res);
        if (!d_ent.step_nz) begin
            d_newp = d_ent.phase;
        end else if (d_sum == '0) begin
            d_newp = PH_MAX;
        end else if (d_sum > T_W'(PH_MAX)) begin
            d_newp = PH_W'(d_sum - T_W'(PH_MAX));
        end else begin
            d_newp = PH_W'(d_sum);
        end
    end

    assign d_tidx = TAB_AW'(d_newp);

    // write-back data for the voice memory
    always_comb begin
        d_wen   = 1'b0;
        d_wdata = d_ent;
        unique case (r_d_op)
            OP_TICK: begin
                d_wen         = r_d_play;
                d_wdata.phase = d_newp;
            end
            OP_NOTE_ON: begin
                d_wen         = 1'b1;
                d_wdata.phase = '0;
            end
            OP_STEP: begin
                d_wen            = 1'b1;
                d_wdata.step_res = r_d_res;
                d_wdata.step_nz  = r_d_nz;
            end
            OP_TABLE: begin
                d_wen = 1'b0;
            end
            default: begin
                d_wen = 1'b0;
            end
        endcase
        d_wen = d_wen && r_d_valid && adv;
    end

    // voice memory write
    always_ff @(posedge i_clk) begin
        if (d_wen) begin
            r_vmem[r_d_voice] <= d_wdata;
        end
    end

    // valid bits and forward register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm_valid <= '0;
            r_fw_valid <= 1'b0;
        end else if (d_wen) begin
            r_vm_valid[r_d_voice] <= 1'b1;
            r_fw_valid            <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (d_wen) begin
            r_fw_voice <= r_d_voice;
            r_fw_data  <= d_wdata;
        end
    end

    // wave table read and write
    always_ff @(posedge i_clk) begin
        if (adv && r_d_valid && (r_d_op == OP_TICK)) begin
            r_tab_rd <= r_tab[d_tidx];
        end
        if (adv && r_d_valid && (r_d_op == OP_TABLE)) begin
            r_tab[r_d_addr] <= r_d_word;
        end
    end

    // ------------------------------------------------------------------
    // output stage
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (adv) begin
            r_e_valid <= r_d_valid && (r_d_op == OP_TICK);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_e_voice  <= VOICE_W'(r_d_voice);
            r_e_last   <= r_d_last;
            r_e_play   <= r_d_play;
            r_e_square <= r_d_square;
            r_e_sqhi   <= (d_newp >= PH_HALF);
            r_e_shift  <= r_d_shift;
        end
    end

    // compare value selection
    always_comb begin
        if (!r_e_play) begin
            o_compare_value = CMP_HALF;
        end else if (r_e_square) begin
            o_compare_value = r_e_sqhi ? CMP_FULL : '0;
        end else begin
            o_compare_value = CMP_W'(r_tab_rd >> r_e_shift);
        end
    end

    assign o_valid     = r_e_valid;
    assign o_out_voice = r_e_voice;
    assign o_last      = r_e_last;

endmodule

FILE: rtl/mvw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvw_checker
// Port-level checks of the oscillator result stream, bound to the top level.
// ----------------------------------------------------------------------------
module mvw_checker
    import mvw_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input logic [VOICE_W-1:0] o_out_voice,
    input logic [CMP_W-1:0]   o_compare_value,
    input logic               o_last
);

    logic               out_beat;
    logic               r_open;
    logic [VOICE_W-1:0] r_prev_voice;
    logic [1:0]         r_cnt;

    assign out_beat = o_valid && !i_stall;

    // track the results of the tick in progress
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open       <= 1'b0;
            r_prev_voice <= '0;
            r_cnt        <= '0;
        end else if (out_beat) begin
            r_open       <= !o_last;
            r_prev_voice <= o_out_voice;
            r_cnt        <= o_last ? 2'd0 : r_cnt + 2'd1;
        end
    end

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_out_voice)
            && $stable(o_compare_value) && $stable(o_last)))
        else $error("stalled result changed");

    // voices of one tick come in rising order
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_beat && r_open) |-> (o_out_voice > r_prev_voice))
        else $error("voice order broken within a tick");

    // a tick ends by its result limit
    a_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_beat && (r_cnt == 2'(RESULT_LIMIT - 1))) |-> o_last)
        else $error("tick gave too many results");

    // no result right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind multi_voice_wavetable_oscillator_core mvw_checker u_mvw_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_out_voice     (o_out_voice),
    .o_compare_value (o_compare_value),
    .o_last          (o_last)
);
